// ===== rtl/core/rvdec_pkg.sv =====
// Shared types, encodings and lookup tables for the RV32IM instruction decoder.
`timescale 1ns / 1ps

package rvdec_pkg;

    localparam int unsigned InstrWidth  = 32;
    localparam int unsigned ResultWidth = 75;
    localparam int unsigned ResultBytes = (ResultWidth + 7) / 8;

    // Major opcodes
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;

    // funct7 values (also the upper immediate bits of the shift-right immediates)
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [6:0] F7_MEXT = 7'b0000001;

    localparam logic [2:0] F3_SR = 3'b101;

    localparam logic [11:0] IMM_ECALL  = 12'd0;
    localparam logic [11:0] IMM_EBREAK = 12'd1;

    typedef enum logic [2:0] {
        FMT_R    = 3'd0,
        FMT_I    = 3'd1,
        FMT_S    = 3'd2,
        FMT_U    = 3'd3,
        FMT_B    = 3'd4,
        FMT_J    = 3'd5,
        FMT_NONE = 3'd6
    } fmt_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_OPCODE = 2'd1,
        ST_BAD_FIELD  = 2'd2
    } status_t;

    typedef enum logic [5:0] {
        I_ILLEGAL, I_LUI, I_AUIPC, I_JAL, I_JALR,
        I_BEQ, I_BNE, I_BLT, I_BGE, I_BLTU, I_BGEU,
        I_LB, I_LH, I_LW, I_LBU, I_LHU,
        I_SB, I_SH, I_SW,
        I_ADDI, I_SLTI, I_SLTIU, I_XORI, I_ORI, I_ANDI, I_SLLI, I_SRLI, I_SRAI,
        I_ADD, I_SUB, I_SLL, I_SLT, I_SLTU, I_XOR, I_SRL, I_SRA, I_OR, I_AND,
        I_MUL, I_MULH, I_MULHSU, I_MULHU, I_DIV, I_DIVU, I_REM, I_REMU,
        I_ECALL, I_EBREAK
    } instr_code_t;

    // Packed so that the format sits in the lowest bits, as on the output stream.
    typedef struct packed {
        logic [1:0]  decode_status;
        logic [5:0]  instruction_code;
        logic [31:0] immediate_value;
        logic [6:0]  func7_field;
        logic [4:0]  src_reg2;
        logic [4:0]  src_reg1;
        logic [2:0]  func3_field;
        logic [4:0]  dest_reg;
        logic [6:0]  major_opcode;
        logic [2:0]  encoding_format;
    } decode_result_t;

    function automatic instr_code_t r_base_code(input logic [2:0] f3);
        instr_code_t c;
        case (f3)
            3'd0:    c = I_ADD;
            3'd1:    c = I_SLL;
            3'd2:    c = I_SLT;
            3'd3:    c = I_SLTU;
            3'd4:    c = I_XOR;
            3'd5:    c = I_SRL;
            3'd6:    c = I_OR;
            default: c = I_AND;
        endcase
        return c;
    endfunction

    function automatic instr_code_t r_alt_code(input logic [2:0] f3);
        instr_code_t c;
        case (f3)
            3'd0:    c = I_SUB;
            3'd5:    c = I_SRA;
            default: c = I_ILLEGAL;
        endcase
        return c;
    endfunction

    function automatic instr_code_t r_mext_code(input logic [2:0] f3);
        instr_code_t c;
        case (f3)
            3'd0:    c = I_MUL;
            3'd1:    c = I_MULH;
            3'd2:    c = I_MULHSU;
            3'd3:    c = I_MULHU;
            3'd4:    c = I_DIV;
            3'd5:    c = I_DIVU;
            3'd6:    c = I_REM;
            default: c = I_REMU;
        endcase
        return c;
    endfunction

    function automatic instr_code_t load_code(input logic [2:0] f3);
        instr_code_t c;
        case (f3)
            3'd0:    c = I_LB;
            3'd1:    c = I_LH;
            3'd2:    c = I_LW;
            3'd4:    c = I_LBU;
            3'd5:    c = I_LHU;
            default: c = I_ILLEGAL;
        endcase
        return c;
    endfunction

    // Shift-right immediates are resolved separately, on imm[11:5].
    function automatic instr_code_t opimm_code(input logic [2:0] f3);
        instr_code_t c;
        case (f3)
            3'd0:    c = I_ADDI;
            3'd1:    c = I_SLLI;
            3'd2:    c = I_SLTI;
            3'd3:    c = I_SLTIU;
            3'd4:    c = I_XORI;
            3'd6:    c = I_ORI;
            3'd7:    c = I_ANDI;
            default: c = I_ILLEGAL;
        endcase
        return c;
    endfunction

    function automatic instr_code_t store_code(input logic [2:0] f3);
        instr_code_t c;
        case (f3)
            3'd0:    c = I_SB;
            3'd1:    c = I_SH;
            3'd2:    c = I_SW;
            default: c = I_ILLEGAL;
        endcase
        return c;
    endfunction

    function automatic instr_code_t branch_code(input logic [2:0] f3);
        instr_code_t c;
        case (f3)
            3'd0:    c = I_BEQ;
            3'd1:    c = I_BNE;
            3'd4:    c = I_BLT;
            3'd5:    c = I_BGE;
            3'd6:    c = I_BLTU;
            3'd7:    c = I_BGEU;
            default: c = I_ILLEGAL;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/rvdec_pipe_reg.sv =====
// One valid/ready register stage that holds a beat until the next stage takes it.
`timescale 1ns / 1ps

module rvdec_pipe_reg #(
    parameter int unsigned WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    // The stage refills in the same cycle that its beat leaves.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

// ===== rtl/core/rvdec_decode.sv =====
// Combinational field extraction, immediate assembly and instruction matching.
`timescale 1ns / 1ps

module rvdec_decode (
    input  logic [31:0]                  raw_instruction,
    output rvdec_pkg::decode_result_t    result
);

    import rvdec_pkg::*;

    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [6:0]  f7;
    logic [11:0] imm12;
    fmt_t        fmt;
    instr_code_t code;
    status_t     status;

    assign op    = raw_instruction[6:0];
    assign rd    = raw_instruction[11:7];
    assign f3    = raw_instruction[14:12];
    assign rs1   = raw_instruction[19:15];
    assign rs2   = raw_instruction[24:20];
    assign f7    = raw_instruction[31:25];
    assign imm12 = raw_instruction[31:20];

    always_comb
    begin
        result              = '0;
        result.major_opcode = op;
        fmt                 = FMT_NONE;
        code                = I_ILLEGAL;

        case (op)
            OPC_OP:
            begin
                fmt                 = FMT_R;
                result.dest_reg     = rd;
                result.func3_field  = f3;
                result.src_reg1     = rs1;
                result.src_reg2     = rs2;
                result.func7_field  = f7;
                if (f7 == F7_BASE)
                begin
                    code = r_base_code(f3);
                end
                else if (f7 == F7_ALT)
                begin
                    code = r_alt_code(f3);
                end
                else if (f7 == F7_MEXT)
                begin
                    code = r_mext_code(f3);
                end
            end
            OPC_OP_IMM, OPC_JALR, OPC_LOAD, OPC_SYSTEM:
            begin
                fmt                    = FMT_I;
                result.dest_reg        = rd;
                result.func3_field     = f3;
                result.src_reg1        = rs1;
                result.immediate_value = {20'd0, imm12};
                case (op)
                    OPC_LOAD:
                    begin
                        code = load_code(f3);
                    end
                    OPC_OP_IMM:
                    begin
                        if (f3 == F3_SR)
                        begin
                            if (f7 == F7_BASE)
                            begin
                                code = I_SRLI;
                            end
                            else if (f7 == F7_ALT)
                            begin
                                code = I_SRAI;
                            end
                        end
                        else
                        begin
                            code = opimm_code(f3);
                        end
                    end
                    OPC_JALR:
                    begin
                        code = I_JALR;
                    end
                    default:
                    begin
                        // SYSTEM: only the whole 12-bit immediate is checked.
                        if (imm12 == IMM_ECALL)
                        begin
                            code = I_ECALL;
                        end
                        else if (imm12 == IMM_EBREAK)
                        begin
                            code = I_EBREAK;
                        end
                    end
                endcase
            end
            OPC_STORE:
            begin
                fmt                    = FMT_S;
                result.func3_field     = f3;
                result.src_reg1        = rs1;
                result.src_reg2        = rs2;
                result.immediate_value = {20'd0, f7, rd};
                code                   = store_code(f3);
            end
            OPC_LUI, OPC_AUIPC:
            begin
                fmt                    = FMT_U;
                result.dest_reg        = rd;
                result.immediate_value = {raw_instruction[31:12], 12'd0};
                code                   = (op == OPC_LUI) ? I_LUI : I_AUIPC;
            end
            OPC_BRANCH:
            begin
                fmt                    = FMT_B;
                result.func3_field     = f3;
                result.src_reg1        = rs1;
                result.src_reg2        = rs2;
                result.immediate_value = {19'd0, raw_instruction[31], raw_instruction[7],
                                          raw_instruction[30:25], raw_instruction[11:8],
                                          1'b0};
                code                   = branch_code(f3);
            end
            OPC_JAL:
            begin
                fmt                    = FMT_J;
                result.dest_reg        = rd;
                result.immediate_value = {11'd0, raw_instruction[31], raw_instruction[19:12],
                                          raw_instruction[20], raw_instruction[30:21],
                                          1'b0};
                code                   = I_JAL;
            end
            default:
            begin
                fmt = FMT_NONE;
            end
        endcase

        if (fmt == FMT_NONE)
        begin
            status = ST_BAD_OPCODE;
        end
        else if (code == I_ILLEGAL)
        begin
            status = ST_BAD_FIELD;
        end
        else
        begin
            status = ST_OK;
        end

        result.encoding_format  = fmt;
        result.instruction_code = code;
        result.decode_status    = status;
    end

endmodule

// ===== rtl/core/rv32im_instruction_decoder_unit.sv =====
// Top level of the RV32IM instruction decoder: input stage, decode logic, result stage.
`timescale 1ns / 1ps

// Usage
// -----
// Instruction words arrive as beats on the s_axis channel, one 32-bit word per
// beat. Each word produces exactly one result beat on the m_axis channel, in
// order, carrying the encoding format, the register and function fields, the
// assembled immediate, the instruction code and a status.
// A word is captured in an input register, decoded by purely combinational
// logic, and the result is captured in an output register, from which it is
// presented on m_axis.
// Throughput is one instruction per cycle while m_axis_tready stays high:
// both register stages refill in the same cycle that they empty, so
// back-to-back beats flow without bubbles.
// When the receiver holds m_axis_tready low, the result stays on m_axis, the
// input stage fills behind it and s_axis_tready falls once both stages hold a
// beat; at most two words are held inside the block.
// Reset (rst_n low, asynchronous) empties both stages; the block keeps no
// other state and needs no configuration.

module rv32im_instruction_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] raw_instruction
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] encoding_format, [9:3] major_opcode, [14:10] dest_reg,
    // [17:15] func3_field, [22:18] src_reg1, [27:23] src_reg2,
    // [34:28] func7_field, [66:35] immediate_value, [72:67] instruction_code,
    // [74:73] decode_status, [79:75] zero
    output logic [rvdec_pkg::ResultBytes*8-1:0] m_axis_tdata
);

    import rvdec_pkg::*;

    logic                   word_valid;
    logic                   word_ready;
    logic [InstrWidth-1:0]  word;
    decode_result_t         dec_result;
    logic [ResultWidth-1:0] out_data;
    decode_result_t         out_res;

    rvdec_pipe_reg #(
        .WIDTH (InstrWidth)
    ) u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (word_valid),
        .out_ready (word_ready),
        .out_data  (word)
    );

    rvdec_decode u_decode (
        .raw_instruction (word),
        .result          (dec_result)
    );

    rvdec_pipe_reg #(
        .WIDTH (ResultWidth)
    ) u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (word_valid),
        .in_ready  (word_ready),
        .in_data   (dec_result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign out_res      = decode_result_t'(out_data);
    assign m_axis_tdata = {{(ResultBytes*8-ResultWidth){1'b0}}, out_data};

    // An accepted word must be held in the input stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> word_valid)
        else $error("accepted instruction word was lost by the input stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_res.decode_status == ST_OK))
            |-> (out_res.instruction_code != I_ILLEGAL))
        else $error("result marked ok without an instruction code");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_res.encoding_format == FMT_NONE))
            |-> ((out_res.decode_status == ST_BAD_OPCODE)
                 && (out_res.immediate_value == '0)
                 && (out_res.dest_reg == '0)
                 && (out_res.instruction_code == I_ILLEGAL)))
        else $error("unknown opcode produced non-zero fields or wrong status");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_res.encoding_format == FMT_R))
            |-> (out_res.immediate_value == '0))
        else $error("register-format result carries an immediate");

endmodule

// ===== bench/decode_checker.sv =====
// Watches both streams of the instruction decoder, predicts each result beat and compares it.
`timescale 1ns / 1ps

module decode_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [31:0]                         s_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [rvdec_pkg::ResultBytes*8-1:0] m_axis_tdata,
    output int                                  fail_count,
    output int                                  outstanding
);

    import rvdec_pkg::*;

    decode_result_t decoded_q[$];

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic decode_result_t predict_decode(input logic [31:0] word);
        decode_result_t r;
        logic [6:0]     opc;
        logic [2:0]     f3;
        logic [6:0]     f7;
        logic [11:0]    imm12;
        instr_code_t    code;
        opc   = word[6:0];
        f3    = word[14:12];
        f7    = word[31:25];
        imm12 = word[31:20];
        code  = I_ILLEGAL;
        r     = '0;
        r.major_opcode = opc;
        case (opc)
            OPC_OP:
            begin
                r.encoding_format = FMT_R;
                r.dest_reg        = word[11:7];
                r.func3_field     = f3;
                r.src_reg1        = word[19:15];
                r.src_reg2        = word[24:20];
                r.func7_field     = f7;
                if (f7 == F7_BASE)
                begin
                    case (f3)
                        3'd0: code = I_ADD;
                        3'd1: code = I_SLL;
                        3'd2: code = I_SLT;
                        3'd3: code = I_SLTU;
                        3'd4: code = I_XOR;
                        3'd5: code = I_SRL;
                        3'd6: code = I_OR;
                        default: code = I_AND;
                    endcase
                end
                else if (f7 == F7_ALT)
                begin
                    if (f3 == 3'd0)
                        code = I_SUB;
                    else if (f3 == F3_SR)
                        code = I_SRA;
                end
                else if (f7 == F7_MEXT)
                begin
                    case (f3)
                        3'd0: code = I_MUL;
                        3'd1: code = I_MULH;
                        3'd2: code = I_MULHSU;
                        3'd3: code = I_MULHU;
                        3'd4: code = I_DIV;
                        3'd5: code = I_DIVU;
                        3'd6: code = I_REM;
                        default: code = I_REMU;
                    endcase
                end
            end
            OPC_OP_IMM, OPC_JALR, OPC_LOAD, OPC_SYSTEM:
            begin
                r.encoding_format = FMT_I;
                r.dest_reg        = word[11:7];
                r.func3_field     = f3;
                r.src_reg1        = word[19:15];
                r.immediate_value = {20'd0, imm12};
                if (opc == OPC_LOAD)
                begin
                    case (f3)
                        3'd0: code = I_LB;
                        3'd1: code = I_LH;
                        3'd2: code = I_LW;
                        3'd4: code = I_LBU;
                        3'd5: code = I_LHU;
                        default: code = I_ILLEGAL;
                    endcase
                end
                else if (opc == OPC_OP_IMM)
                begin
                    case (f3)
                        3'd0: code = I_ADDI;
                        3'd1: code = I_SLLI;
                        3'd2: code = I_SLTI;
                        3'd3: code = I_SLTIU;
                        3'd4: code = I_XORI;
                        3'd6: code = I_ORI;
                        3'd7: code = I_ANDI;
                        default:
                        begin
                            // Shift right: the upper immediate bits pick logical or arithmetic.
                            if (imm12[11:5] == F7_BASE)
                                code = I_SRLI;
                            else if (imm12[11:5] == F7_ALT)
                                code = I_SRAI;
                        end
                    endcase
                end
                else if (opc == OPC_JALR)
                    code = I_JALR;
                else if (imm12 == IMM_ECALL)
                    code = I_ECALL;
                else if (imm12 == IMM_EBREAK)
                    code = I_EBREAK;
            end
            OPC_STORE:
            begin
                r.encoding_format = FMT_S;
                r.func3_field     = f3;
                r.src_reg1        = word[19:15];
                r.src_reg2        = word[24:20];
                r.immediate_value = {20'd0, f7, word[11:7]};
                case (f3)
                    3'd0: code = I_SB;
                    3'd1: code = I_SH;
                    3'd2: code = I_SW;
                    default: code = I_ILLEGAL;
                endcase
            end
            OPC_LUI, OPC_AUIPC:
            begin
                r.encoding_format = FMT_U;
                r.dest_reg        = word[11:7];
                r.immediate_value = {word[31:12], 12'd0};
                code = (opc == OPC_LUI) ? I_LUI : I_AUIPC;
            end
            OPC_BRANCH:
            begin
                r.encoding_format = FMT_B;
                r.func3_field     = f3;
                r.src_reg1        = word[19:15];
                r.src_reg2        = word[24:20];
                r.immediate_value = {19'd0, word[31], word[7], word[30:25], word[11:8], 1'b0};
                case (f3)
                    3'd0: code = I_BEQ;
                    3'd1: code = I_BNE;
                    3'd4: code = I_BLT;
                    3'd5: code = I_BGE;
                    3'd6: code = I_BLTU;
                    3'd7: code = I_BGEU;
                    default: code = I_ILLEGAL;
                endcase
            end
            OPC_JAL:
            begin
                r.encoding_format = FMT_J;
                r.dest_reg        = word[11:7];
                r.immediate_value = {11'd0, word[31], word[19:12], word[20], word[30:21], 1'b0};
                code = I_JAL;
            end
            default:
            begin
                r.encoding_format = FMT_NONE;
            end
        endcase
        r.instruction_code = code;
        if (r.encoding_format == FMT_NONE)
            r.decode_status = ST_BAD_OPCODE;
        else if (code == I_ILLEGAL)
            r.decode_status = ST_BAD_FIELD;
        else
            r.decode_status = ST_OK;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen)
        begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, seen);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        decode_result_t want;
        decode_result_t seen;
        if (rst_n)
        begin
            // The result of a word is never taken at the edge that accepts it,
            // so the oldest prediction is popped before the new one is pushed.
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = m_axis_tdata[ResultWidth-1:0];
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: result beat 0x%0h arrived with nothing expected",
                             $time, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("encoding_format", 32'(want.encoding_format),
                                32'(seen.encoding_format));
                    check_field("major_opcode", 32'(want.major_opcode),
                                32'(seen.major_opcode));
                    check_field("dest_reg", 32'(want.dest_reg), 32'(seen.dest_reg));
                    check_field("func3_field", 32'(want.func3_field),
                                32'(seen.func3_field));
                    check_field("src_reg1", 32'(want.src_reg1), 32'(seen.src_reg1));
                    check_field("src_reg2", 32'(want.src_reg2), 32'(seen.src_reg2));
                    check_field("func7_field", 32'(want.func7_field),
                                32'(seen.func7_field));
                    check_field("immediate_value", want.immediate_value,
                                seen.immediate_value);
                    check_field("instruction_code", 32'(want.instruction_code),
                                32'(seen.instruction_code));
                    check_field("decode_status", 32'(want.decode_status),
                                32'(seen.decode_status));
                    check_field("tdata padding", '0,
                                32'(m_axis_tdata[ResultBytes*8-1:ResultWidth]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decoded_q.push_back(predict_decode(s_axis_tdata));
            outstanding <= decoded_q.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the instruction decoder bench: clock, reset, stream stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;

    import rvdec_pkg::*;

    localparam int RandomWords = 1850;
    localparam int HoldCycles  = 60;
    localparam int CycleLimit  = 200000;

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [31:0]              s_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [ResultBytes*8-1:0] m_axis_tdata;

    int fail_count;
    int outstanding;
    int cycles;
    int hold_requests;
    int holds_served;
    bit idle_on;

    rv32im_instruction_decoder_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    decode_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        hold_requests = 0;
        holds_served  = 0;
        idle_on       = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Receiver: random stalls while idle_on is set, and a long hold-off whenever one is requested.
    initial
    begin
        @(posedge clk iff rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                holds_served++;
            end
            m_axis_tready <= !(idle_on && $urandom_range(99) < 12);
        end
    end

    function automatic logic [31:0] make_word(input logic [6:0] opc, input logic [4:0] rd,
                                              input logic [2:0] f3, input logic [4:0] rs1,
                                              input logic [4:0] rs2, input logic [6:0] f7);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    // Mostly well-formed words with random content; the rest is plain noise.
    function automatic logic [31:0] random_instruction();
        logic [31:0] word;
        logic [6:0]  opc;
        word = $urandom;
        case ($urandom_range(9))
            0: opc = OPC_OP;
            1: opc = OPC_OP_IMM;
            2: opc = OPC_JALR;
            3: opc = OPC_LOAD;
            4: opc = OPC_SYSTEM;
            5: opc = OPC_STORE;
            6: opc = OPC_LUI;
            7: opc = OPC_AUIPC;
            8: opc = OPC_BRANCH;
            default: opc = OPC_JAL;
        endcase
        if ($urandom_range(19) < 2)
            return word;
        word[6:0] = opc;
        if (opc == OPC_OP)
        begin
            case ($urandom_range(3))
                0: word[31:25] = F7_BASE;
                1: word[31:25] = F7_ALT;
                2: word[31:25] = F7_MEXT;
                default: ;
            endcase
        end
        else if (opc == OPC_OP_IMM)
        begin
            if ($urandom_range(3) == 0)
                word[14:12] = F3_SR;
            case ($urandom_range(2))
                0: word[31:25] = F7_BASE;
                1: word[31:25] = F7_ALT;
                default: ;
            endcase
        end
        else if (opc == OPC_SYSTEM)
        begin
            case ($urandom_range(2))
                0: word[31:20] = IMM_ECALL;
                1: word[31:20] = IMM_EBREAK;
                default: ;
            endcase
        end
        return word;
    endfunction

    task automatic send_word(input logic [31:0] word);
        int gap;
        s_axis_tdata  <= word;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (idle_on && $urandom_range(99) < 12)
        begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering beats until every predicted result has been taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        @(posedge clk iff rst_n);
        @(posedge clk);

        // Directed words: field extremes, each format and the illegal encodings.
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(make_word(OPC_OP, 5'd31, 3'd0, 5'd31, 5'd31, F7_BASE));
        send_word(make_word(OPC_OP, 5'd1, 3'd0, 5'd2, 5'd3, F7_ALT));
        send_word(make_word(OPC_OP, 5'd5, F3_SR, 5'd6, 5'd7, F7_ALT));
        send_word(make_word(OPC_OP, 5'd5, 3'd3, 5'd6, 5'd7, F7_ALT));
        send_word(make_word(OPC_OP, 5'd9, 3'd7, 5'd10, 5'd11, F7_MEXT));
        send_word(make_word(OPC_OP, 5'd9, 3'd0, 5'd10, 5'd11, 7'h7F));
        send_word(make_word(OPC_LOAD, 5'd31, 3'd3, 5'd31, 5'd31, 7'h7F));
        send_word(make_word(OPC_LOAD, 5'd2, 3'd5, 5'd3, 5'd0, 7'h00));
        send_word(make_word(OPC_STORE, 5'd31, 3'd2, 5'd31, 5'd31, 7'h7F));
        send_word(make_word(OPC_STORE, 5'd0, 3'd4, 5'd0, 5'd0, 7'h00));
        send_word(make_word(OPC_BRANCH, 5'd31, 3'd7, 5'd31, 5'd31, 7'h7F));
        send_word(make_word(OPC_BRANCH, 5'd0, 3'd2, 5'd1, 5'd2, 7'h00));
        send_word(make_word(OPC_OP_IMM, 5'd1, F3_SR, 5'd2, 5'd31, F7_BASE));
        send_word(make_word(OPC_OP_IMM, 5'd1, F3_SR, 5'd2, 5'd31, F7_ALT));
        send_word(make_word(OPC_OP_IMM, 5'd1, F3_SR, 5'd2, 5'd31, F7_MEXT));
        send_word(make_word(OPC_OP_IMM, 5'd1, 3'd1, 5'd2, 5'd3, 7'h7F));
        send_word(make_word(OPC_JALR, 5'd4, 3'd7, 5'd5, 5'd31, 7'h7F));
        send_word(make_word(OPC_SYSTEM, 5'd31, 3'd7, 5'd31, 5'd0, 7'h00));
        send_word(make_word(OPC_SYSTEM, 5'd0, 3'd0, 5'd0, 5'd1, 7'h00));
        send_word(make_word(OPC_SYSTEM, 5'd0, 3'd0, 5'd0, 5'd2, 7'h00));
        send_word({20'hFFFFF, 5'd31, OPC_LUI});
        send_word({20'h00001, 5'd0, OPC_AUIPC});
        send_word({25'h1FF_FFFF, OPC_JAL});
        drain_results();

        for (int i = 0; i < RandomWords; i++)
        begin
            if (i == 500)
                hold_requests++;
            if (i == 900)
                drain_results();
            if (i == 1100)
                idle_on = 1'b0;
            if (i == 1400)
                idle_on = 1'b1;
            send_word(random_instruction());
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
